// File: rtl/core/drtt_pkg.sv
// Shared types and constants of the delayed ramp transition timer.
`timescale 1ns / 1ps

package drtt_pkg;

  localparam int unsigned TIME_BITS  = 24;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ELAPSED_W  = TIME_BITS + 1;
  localparam int unsigned POS_W      = FRAC_BITS + 1;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CNT_W      = $clog2(FRAC_BITS);

  localparam logic [POS_W-1:0]     FRAC_ONE = POS_W'(1) << FRAC_BITS;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  localparam logic [CNT_W-1:0]     DIV_LAST = CNT_W'(FRAC_BITS - 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_START_FWD = 2'd1,
    FUNC_START_BWD = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_LENGTH = 2'd0,
    CFG_WAIT_LENGTH = 2'd1,
    CFG_LOOP_ENABLE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_RAMP  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_ADJUST,
    S_PREP,
    S_DIV,
    S_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic adjust;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } status_t;

endpackage

// File: rtl/core/drtt_ctrl.sv
// Sequencing state machine of the delayed ramp transition timer.
`timescale 1ns / 1ps

module drtt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output drtt_pkg::cmd_t  cmd_o,
  input  drtt_pkg::status_t status_i
);
  import drtt_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_UPDATE;
      end
      S_UPDATE: state_d = S_ADJUST;
      S_ADJUST: begin
        state_d = status_i.emit ? S_PREP : S_IDLE;
      end
      S_PREP: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == DIV_LAST) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_UPDATE: cmd_o.update = 1'b1;
      S_ADJUST: cmd_o.adjust = status_i.emit;
      S_PREP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
      end
      S_LOAD: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result still waiting at the output is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");

  // The divider runs for exactly one step per quotient bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && state_d == S_LOAD) |-> cnt_q == DIV_LAST)
    else $error("division left early or late");

  // Starting a division is only done for a tick that produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_init |-> $past(status_i.emit))
    else $error("division started without a pending result");

endmodule

// File: rtl/core/drtt_datapath.sv
// Datapath of the delayed ramp transition timer: registers, update and divider.
`timescale 1ns / 1ps

module drtt_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [drtt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drtt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [drtt_pkg::FUNC_W-1:0]     func_i,
  input  logic [drtt_pkg::STEP_W-1:0]     time_step_i,
  input  drtt_pkg::cmd_t                  cmd_i,
  output drtt_pkg::status_t               status_o,
  output logic [drtt_pkg::POS_W-1:0]      ramp_position_o,
  output logic                            wrapped_o,
  output logic                            last_one_o
);
  import drtt_pkg::*;

  logic [TIME_BITS-1:0] ramp_length_q, wait_length_q;
  logic                 loop_enable_q;

  phase_e               phase_q;
  logic                 backward_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic                 emit_q, wrapped_q, last_one_q;

  logic [FUNC_W-1:0]    func_q;
  logic [STEP_W-1:0]    step_q;

  logic [TIME_BITS-1:0] rem_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic                 sat_q;

  logic [POS_W-1:0]     pos_q;
  logic                 pos_wrapped_q, pos_last_q;

  logic [ELAPSED_W:0]   sum_wide;
  logic [ELAPSED_W-1:0] sum_sat;
  logic [ELAPSED_W-1:0] len_ext;
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS:0]   rem_diff;
  logic [POS_W-1:0]     frac;
  logic [POS_W-1:0]     pos_next;

  // Saturating add of the time step onto the elapsed time.
  assign sum_wide = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(step_q);
  assign sum_sat  = sum_wide[ELAPSED_W] ? ELAPSED_MAX : sum_wide[ELAPSED_W-1:0];
  assign len_ext  = {1'b0, ramp_length_q};

  // One restoring division step.
  assign rem_sh   = {rem_q, 1'b0};
  assign rem_diff = rem_sh - {1'b0, ramp_length_q};

  assign frac     = sat_q ? FRAC_ONE : {1'b0, quo_q};
  assign pos_next = backward_q ? (FRAC_ONE - frac) : frac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_length_q <= '0;
      wait_length_q <= '0;
      loop_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RAMP_LENGTH: ramp_length_q <= cfg_data_i[TIME_BITS-1:0];
        CFG_WAIT_LENGTH: wait_length_q <= cfg_data_i[TIME_BITS-1:0];
        CFG_LOOP_ENABLE: loop_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      backward_q <= 1'b0;
      elapsed_q  <= '0;
      emit_q     <= 1'b0;
      wrapped_q  <= 1'b0;
      last_one_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        emit_q     <= 1'b0;
        wrapped_q  <= 1'b0;
        last_one_q <= 1'b0;
      end
      if (cmd_i.update) begin
        case (func_q)
          FUNC_START_FWD, FUNC_START_BWD: begin
            backward_q <= (func_q == FUNC_START_BWD);
            phase_q    <= PH_DELAY;
            elapsed_q  <= '0;
          end
          FUNC_TICK: begin
            if (phase_q == PH_DELAY) begin
              if (sum_sat >= {1'b0, wait_length_q}) begin
                phase_q   <= PH_RAMP;
                elapsed_q <= '0;
              end else begin
                elapsed_q <= sum_sat;
              end
            end else if (phase_q == PH_RAMP) begin
              elapsed_q <= sum_sat;
              emit_q    <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.adjust && (elapsed_q > len_ext)) begin
        if (loop_enable_q) begin
          elapsed_q <= elapsed_q - len_ext;
          wrapped_q <= 1'b1;
        end else begin
          elapsed_q  <= len_ext;
          phase_q    <= PH_IDLE;
          last_one_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers: captured item, divider and output result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      step_q <= time_step_i;
    end
    if (cmd_i.div_init) begin
      sat_q <= (ramp_length_q == '0) || (elapsed_q >= len_ext);
      rem_q <= elapsed_q[TIME_BITS-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, ramp_length_q}) begin
        rem_q <= rem_diff[TIME_BITS-1:0];
        quo_q <= {quo_q[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[TIME_BITS-1:0];
        quo_q <= {quo_q[FRAC_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      pos_q         <= pos_next;
      pos_wrapped_q <= wrapped_q;
      pos_last_q    <= last_one_q;
    end
  end

  assign status_o.emit   = emit_q;
  assign ramp_position_o = pos_q;
  assign wrapped_o       = pos_wrapped_q;
  assign last_one_o      = pos_last_q;

  // A one-shot ramp that has just finished rests idle at its full length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(last_one_q) |-> (phase_q == PH_IDLE && elapsed_q == len_ext))
    else $error("finished ramp not clamped to its length");

  // The partial remainder stays below the divisor while dividing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !sat_q) |-> (rem_q < ramp_length_q))
    else $error("divider remainder out of range");

endmodule

// File: rtl/core/delayed_ramp_transition_timer.sv
// Top level of the delayed ramp transition timer: controller plus datapath.
// A tick in the transition phase passes through update, adjustment, division
// and load, and gives a result; other items end after adjustment with none.
// One item is handled at a time, so no new item is taken until the last is done;
// the limit is the bit-serial restoring divider, forming one quotient bit per cycle.
// Reset is asynchronous and active low; it clears configuration, phase and state.
`timescale 1ns / 1ps

module delayed_ramp_transition_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input item channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [drtt_pkg::FUNC_W-1:0]     func_i,
  input  logic [drtt_pkg::STEP_W-1:0]     time_step_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [drtt_pkg::POS_W-1:0]      ramp_position_o,
  output logic                            wrapped_o,
  output logic                            last_one_o,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [drtt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drtt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import drtt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always taken; the user must issue them only while
  // the block is idle; the block itself does not enforce this (no interlock).
  assign cfg_ready_o = 1'b1;

  // The controller walks each transfer through update, adjustment and, for
  // ticks in the transition phase, the division that forms the position.
  // The result register is loaded only once any earlier result has gone.
  drtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath holds the configuration, the ramp state and the divider.
  drtt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .time_step_i     (time_step_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .ramp_position_o (ramp_position_o),
    .wrapped_o       (wrapped_o),
    .last_one_o      (last_one_o)
  );

endmodule
